// ===== hw/rtl/sact_pkg.sv =====
// ----------------------------------------------------------------------------
// sact_pkg
// Shared types and constants of the set-associative cache tag lookup: the
// command and status words between controller and datapath, port widths,
// register map and the replacement LFSR.
// ----------------------------------------------------------------------------
package sact_pkg;

  // fixed port widths
  localparam int ADDR_PORT_W = 64;
  localparam int WAY_OUT_W   = 3;
  localparam int COUNT_W     = 32;

  // configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_IDX_W   = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'b0;

  // replacement policy codes
  localparam logic POLICY_LRU    = 1'b0;
  localparam logic POLICY_RANDOM = 1'b1;

  // galois lfsr for random victims
  localparam int               LFSR_W    = 16;
  localparam logic [15:0]      LFSR_TAPS = 16'hB400;
  localparam logic [15:0]      LFSR_SEED = 16'h0001;

  // set divider works through the line number one slice at a time
  localparam int DIV_CHUNK_W = 16;

  // controller to datapath
  typedef struct packed {
    logic clr_wr;    // write one cleared row during the reset sweep
    logic load;      // capture an accepted address word
    logic rd_in;     // read the set row indexed straight from the address
    logic div_mul;   // estimate the quotient slice of line / sets
    logic div_step;  // correct the slice, shift it in and keep the remainder
    logic rd_rem;    // read the set row indexed by the divider remainder
    logic commit;    // write back the row and load the result word
  } sact_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;  // clearing sweep is at its last row
    logic out_free;  // result register can take a word this cycle
  } sact_sts_t;

  // one lfsr step
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] nxt;
    nxt = s >> 1;
    if (s[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

endpackage

// ===== hw/rtl/sact_ctrl.sv =====
// ----------------------------------------------------------------------------
// sact_ctrl
// Sequencer of the tag lookup: clearing sweep after reset, address accept,
// optional slice-wise set division, set row read, compare and write-back.
// ----------------------------------------------------------------------------
module sact_ctrl #(
  parameter bit USE_DIV   = 1'b0,
  parameter int DIV_STEPS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sact_pkg::sact_sts_t sts,
  output sact_pkg::sact_cmd_t cmd
);

  localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_LOOKUP
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cmd.rd_in = !USE_DIV;
          cnt_nxt   = '0;
          state_nxt = USE_DIV ? ST_DIVIDE : ST_LOOKUP;
        end
      end
      ST_DIVIDE: begin
        // even steps estimate a slice, odd steps correct and shift it in
        cmd.div_mul  = !cnt_r[0];
        cmd.div_step = cnt_r[0];
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_rem = 1'b1;
        state_nxt  = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and step count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // take a word only when nothing is in flight
  assign in_stall = (state_r != ST_IDLE);

endmodule

// ===== hw/rtl/sact_datapath.sv =====
// ----------------------------------------------------------------------------
// sact_datapath
// Set row memory (valid, age and tag of every way), address split, set
// divider, tag compare, victim choice, age upkeep, counters and the result
// register.
// ----------------------------------------------------------------------------
module sact_datapath #(
  parameter int WAYS        = 8,
  parameter int SETS        = 128,
  parameter int OFFSET_BITS = 5,
  parameter int ADDR_BITS   = 64,
  parameter bit USE_DIV     = 1'b0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [sact_pkg::ADDR_PORT_W-1:0]    in_address,
  input  logic                                policy,
  input  sact_pkg::sact_cmd_t                 cmd,
  output sact_pkg::sact_sts_t                 sts,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [sact_pkg::WAY_OUT_W-1:0]      out_way,
  output logic                                out_replaced_valid,
  output logic [sact_pkg::COUNT_W-1:0]        out_hit_total,
  output logic [sact_pkg::COUNT_W-1:0]        out_miss_total
);

  localparam int WAY_W    = $clog2(WAYS);
  localparam int AGE_W    = WAY_W;
  localparam int LINE_W   = ADDR_BITS - OFFSET_BITS;
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_BITS = $clog2(SETS + 1) - 1;
  localparam int TAG_W    = LINE_W - SET_BITS;
  localparam int ROW_W    = WAYS * (1 + AGE_W + TAG_W);
  localparam int LFSR_W   = sact_pkg::LFSR_W;
  localparam int COUNT_W  = sact_pkg::COUNT_W;
  // reciprocal for the random way: q = (x * RAND_M) >> RAND_S is x / WAYS
  localparam int RAND_S   = LFSR_W + WAY_W;
  localparam int RAND_M   = ((2 ** RAND_S) + WAYS - 1) / WAYS;
  localparam int RAND_M_W = LFSR_W + 1;
  localparam int PROD_W   = LFSR_W + RAND_M_W;
  localparam int Q_W      = PROD_W - RAND_S;
  // set divider: line number in slices, each slice divided by a reciprocal
  // estimate that is low by at most one and then corrected
  localparam int CH_W    = sact_pkg::DIV_CHUNK_W;
  localparam int N_CH    = (LINE_W + CH_W - 1) / CH_W;
  localparam int PAD_W   = N_CH * CH_W;
  localparam int PART_W  = SET_W + CH_W;
  localparam int RCP_W   = CH_W + 1;
  localparam int DPROD_W = PART_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << PART_W) / SETS);

  // set row memory
  logic [ROW_W-1:0] store_mem [SETS];
  logic [ROW_W-1:0] rd_row_r;
  logic [SET_W-1:0] rd_addr;
  logic [ROW_W-1:0] wr_row;
  logic [SET_W-1:0] clr_idx_r;

  // address split and divider
  logic [PAD_W-1:0]   line_r;
  logic [SET_W-1:0]   rem_r;
  logic [SET_W-1:0]   in_set;
  logic [PART_W-1:0]  div_part;
  logic [DPROD_W-1:0] div_prod;
  logic [CH_W-1:0]    dq_r;
  logic [PART_W-1:0]  div_back;
  logic [PART_W-1:0]  div_rest;
  logic [PART_W-1:0]  div_less;
  logic               div_ge;
  logic [CH_W-1:0]    dq_fix;
  logic [TAG_W-1:0]   tag_cur;

  // row fields
  logic [WAYS-1:0]             rd_valid;
  logic [WAYS-1:0][AGE_W-1:0]  rd_age;
  logic [WAYS-1:0][TAG_W-1:0]  rd_tag;
  logic [WAYS-1:0]             new_valid;
  logic [WAYS-1:0][AGE_W-1:0]  new_age;
  logic [WAYS-1:0][TAG_W-1:0]  new_tag;

  // lookup
  logic [WAYS-1:0]  match;
  logic [WAYS-1:0]  age_zero;
  logic             hit;
  logic             has_free;
  logic             evict;
  logic             rand_use;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] lru_way;
  logic [WAY_W-1:0] rand_way;
  logic [WAY_W-1:0] victim;
  logic [AGE_W-1:0] base_age;

  // random way
  logic [LFSR_W-1:0] lfsr_r;
  logic [LFSR_W-1:0] lfsr_adv;
  logic [PROD_W-1:0] rand_prod;
  logic [Q_W-1:0]    rand_q_r;
  logic [LFSR_W-1:0] rand_qw;
  logic [LFSR_W-1:0] rand_rem;

  // counters and result
  logic [COUNT_W-1:0]             hits_r;
  logic [COUNT_W-1:0]             misses_r;
  logic [COUNT_W-1:0]             hits_nxt;
  logic [COUNT_W-1:0]             misses_nxt;
  logic                           out_valid_r;
  logic                           out_hit_r;
  logic [sact_pkg::WAY_OUT_W-1:0] out_way_r;
  logic                           out_repl_r;

  // set index straight from the address when the set count is a power of two
  assign in_set = (SETS == 1) ? '0 : in_address[OFFSET_BITS +: SET_W];

  // divider slice: remainder so far followed by the next line slice
  assign div_part = {rem_r, line_r[PAD_W-1 -: CH_W]};
  assign div_prod = DPROD_W'(div_part) * DPROD_W'(RCP);

  // correction: the estimate is the slice quotient or one below it
  assign div_back = PART_W'(dq_r) * PART_W'(SETS);
  assign div_rest = div_part - div_back;
  assign div_ge   = (div_rest >= PART_W'(SETS));
  assign div_less = div_rest - PART_W'(SETS);
  assign dq_fix   = div_ge ? (dq_r + 1'b1) : dq_r;

  // tag is the quotient, either shifted out or left by the divider
  assign tag_cur = USE_DIV ? line_r[TAG_W-1:0] : line_r[LINE_W-1 -: TAG_W];

  // address capture and division
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      line_r <= PAD_W'(in_address[ADDR_BITS-1:OFFSET_BITS]);
      rem_r  <= USE_DIV ? '0 : in_set;
    end else if (cmd.div_step) begin
      line_r <= {line_r[PAD_W-CH_W-1:0], dq_fix};
      rem_r  <= div_ge ? div_less[SET_W-1:0] : div_rest[SET_W-1:0];
    end
    if (cmd.div_mul) begin
      dq_r <= div_prod[PART_W +: CH_W];
    end
  end

  // clearing sweep index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign sts.clr_done = (clr_idx_r == SET_W'(SETS - 1));

  // row memory: one read and one write port
  assign rd_addr = cmd.rd_in ? in_set : rem_r;
  assign wr_row  = {new_tag, new_age, new_valid};

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      store_mem[clr_idx_r] <= '0;
    end else if (cmd.commit) begin
      store_mem[rem_r] <= wr_row;
    end
    if (cmd.rd_in || cmd.rd_rem) begin
      rd_row_r <= store_mem[rd_addr];
    end
  end

  assign rd_valid = rd_row_r[WAYS-1:0];
  assign rd_age   = rd_row_r[WAYS +: WAYS*AGE_W];
  assign rd_tag   = rd_row_r[WAYS*(1+AGE_W) +: WAYS*TAG_W];

  // random way: quotient registered ahead, remainder at use
  assign lfsr_adv  = sact_pkg::lfsr_step(lfsr_r);
  assign rand_prod = PROD_W'(lfsr_adv) * PROD_W'(RAND_M);
  assign rand_qw   = LFSR_W'(rand_q_r) * LFSR_W'(WAYS);
  assign rand_rem  = lfsr_adv - rand_qw;
  assign rand_way  = rand_rem[WAY_W-1:0];

  always_ff @(posedge clk) begin
    rand_q_r <= rand_prod[RAND_S +: Q_W];
  end

  // compare, victim choice and age upkeep
  always_comb begin
    match    = '0;
    age_zero = '0;
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w]    = rd_valid[w] && (rd_tag[w] == tag_cur);
      age_zero[w] = (rd_age[w] == '0);
    end
    hit      = |match;
    has_free = ~&rd_valid;
    // lowest-numbered way wins each pick
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (!rd_valid[w]) begin
        free_way = WAY_W'(w);
      end
      if (age_zero[w]) begin
        lru_way = WAY_W'(w);
      end
    end
    evict    = !hit && !has_free;
    rand_use = evict && (policy == sact_pkg::POLICY_RANDOM);
    if (hit) begin
      victim = hit_way;
    end else if (has_free) begin
      victim = free_way;
    end else if (rand_use) begin
      victim = rand_way;
    end else begin
      victim = lru_way;
    end
    // a fill into an empty way ages every valid way
    base_age = (!hit && has_free) ? '0 : rd_age[victim];
    for (int v = 0; v < WAYS; v++) begin
      new_age[v] = rd_age[v];
      if (rd_valid[v] && (rd_age[v] > base_age)) begin
        new_age[v] = rd_age[v] - 1'b1;
      end
    end
    new_age[victim]   = AGE_W'(WAYS - 1);
    new_valid         = rd_valid;
    new_valid[victim] = 1'b1;
    new_tag           = rd_tag;
    new_tag[victim]   = tag_cur;
  end

  assign hits_nxt   = hits_r + COUNT_W'(hit);
  assign misses_nxt = misses_r + COUNT_W'(!hit);

  // lfsr, counters and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r      <= sact_pkg::LFSR_SEED;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit && rand_use) begin
        lfsr_r <= lfsr_adv;
      end
      if (cmd.commit) begin
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r  <= hit;
      out_way_r  <= sact_pkg::WAY_OUT_W'(victim);
      out_repl_r <= evict;
    end
  end

  assign sts.out_free       = !out_valid_r || !out_stall;
  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_way            = out_way_r;
  assign out_replaced_valid = out_repl_r;
  assign out_hit_total      = hits_r;
  assign out_miss_total     = misses_r;

  // a full set always holds exactly one oldest way
  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && (&rd_valid) |-> $onehot(age_zero))
    else $error("full set without a single oldest way");

  // a tag lives in at most one way of its set
  a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $onehot0(match))
    else $error("tag matches more than one way");

  // random victim stays inside the set
  a_rand_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && rand_use |-> (rand_way <= WAY_W'(WAYS - 1)))
    else $error("random victim beyond way count");

  // every lookup bumps exactly one counter and shows a word
  a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r &&
      ((hits_r + misses_r) == COUNT_W'($past(hits_r) + $past(misses_r) + 1'b1)))
    else $error("lookup did not count once");

endmodule

// ===== hw/rtl/set_assoc_cache_tag_lookup.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lookup
// Tag store of a set-associative cache with least recently used or
// pseudo-random replacement, hit and miss counters and an APB policy register.
// ----------------------------------------------------------------------------
// Each address word is split into offset, set and tag; the tag is compared
// against the valid ways of its set, and a miss fills the lowest invalid way
// or evicts the oldest way (policy 0) or an LFSR-chosen way (policy 1). One
// result word comes out per address. When SETS is a power of two, the set
// row is read from the row memory as the address is taken and is then
// compared and written back. Otherwise the set index and tag come from a
// divider that works through the line number 16 bits at a time, each slice
// first estimated and then corrected and shifted in, before the set row is
// read, compared and written back.
// The next address is taken while a result still waits on out_stall; a held
// result stops the lookup only when a second one is ready. After reset the
// block clears one set row per cycle, all SETS of them, before it takes an
// address; the policy register can be written at any time meanwhile.
module set_assoc_cache_tag_lookup #(
  parameter int WAYS        = 8,
  parameter int SETS        = 128,
  parameter int OFFSET_BITS = 5,
  parameter int ADDR_BITS   = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // address words
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [sact_pkg::ADDR_PORT_W-1:0]     in_address,
  // result words
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_hit,
  output logic [sact_pkg::WAY_OUT_W-1:0]       out_way,
  output logic                                 out_replaced_valid,
  output logic [sact_pkg::COUNT_W-1:0]         out_hit_total,
  output logic [sact_pkg::COUNT_W-1:0]         out_miss_total,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sact_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [sact_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [sact_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int  SET_BITS   = $clog2(SETS + 1) - 1;
  localparam bit  USE_DIV    = (SETS != (1 << SET_BITS));
  localparam int  LINE_W     = ADDR_BITS - OFFSET_BITS;
  localparam int  DIV_CHUNKS = (LINE_W + sact_pkg::DIV_CHUNK_W - 1) / sact_pkg::DIV_CHUNK_W;

  sact_pkg::sact_cmd_t                 cmd;
  sact_pkg::sact_sts_t                 sts;
  logic                                policy_r;
  logic [sact_pkg::CFG_IDX_W-1:0]      cfg_idx;
  logic                                cfg_wr;

  // register decode: one 32-bit register per word address
  assign cfg_idx = paddr[sact_pkg::CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= sact_pkg::POLICY_LRU;
    end else if (cfg_wr && (cfg_idx == sact_pkg::REG_POLICY)) begin
      policy_r <= pwdata[0];
    end
  end

  assign prdata = (cfg_idx == sact_pkg::REG_POLICY) ?
                  sact_pkg::CFG_DATA_W'(policy_r) : '0;

  // sequencer
  sact_ctrl #(
    .USE_DIV   (USE_DIV),
    .DIV_STEPS (2 * DIV_CHUNKS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // row memory, compare and result
  sact_datapath #(
    .WAYS        (WAYS),
    .SETS        (SETS),
    .OFFSET_BITS (OFFSET_BITS),
    .ADDR_BITS   (ADDR_BITS),
    .USE_DIV     (USE_DIV)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_address         (in_address),
    .policy             (policy_r),
    .cmd                (cmd),
    .sts                (sts),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_way            (out_way),
    .out_replaced_valid (out_replaced_valid),
    .out_hit_total      (out_hit_total),
    .out_miss_total     (out_miss_total)
  );

endmodule
